>>> src/dequant_int8_weight_mac_4ch_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dequantizing MAC block
// Concurrent assertion wrappers; they expand to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef DEQUANT_INT8_WEIGHT_MAC_4CH_TOP_ASSERT_SVH
`define DEQUANT_INT8_WEIGHT_MAC_4CH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define DQM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define DQM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DQM_ASSERT(lbl, clk, rst_n, prop, msg)
`define DQM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> src/dqm_pkg.sv
// ---------------------------------------------------------------------------
// dqm_pkg
// Shared widths, codes, command/status types and saturation helpers.
// ---------------------------------------------------------------------------
package dqm_pkg;

    localparam int DQM_LANES   = 4;   // default lane count
    localparam int DQM_RESULTS = 4;   // weight and result ports
    localparam int DATA_W      = 32;
    localparam int WGT_W       = 8;
    localparam int CH_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int FRAC_W      = 16;

    localparam logic OP_SETUP = 1'b0;
    localparam logic OP_ACCUM = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLAMP_LOW  = 2'd0,
        CFG_CLAMP_HIGH = 2'd1,
        CFG_ACC_PRIOR  = 2'd2,
        CFG_BIAS_EN    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic setup_we;   // store channel setup, load start value
        logic deq_load;   // register dequantized weights and activation
        logic mul_en;     // register lane products
        logic acc_en;     // update accumulators
        logic out_load;   // load clamped sums into output register
    } t_dqm_cmd;

    typedef struct packed {
        logic out_free;   // output register can take a beat this cycle
    } t_dqm_sts;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < 64'shFFFF_FFFF_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = signed'(x[DATA_W-1:0]);
        end
        return r;
    endfunction

    // upper bound first, so an inverted range yields the lower bound
    function automatic logic signed [DATA_W-1:0] clamp32(
        input logic signed [DATA_W-1:0] v,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [DATA_W-1:0] r;
        r = v;
        if (r > hi) begin
            r = hi;
        end
        if (r < lo) begin
            r = lo;
        end
        return r;
    endfunction

endpackage

>>> src/dequant_int8_weight_mac_4ch_top.sv
// ---------------------------------------------------------------------------
// dequant_int8_weight_mac_4ch_top
// Four-channel MAC with per-channel dequantized int8 weights, Q16.16 data.
// ---------------------------------------------------------------------------
// Items are taken one at a time. A setup item is stored at acceptance. An
// accumulate item registers the dequantized weights at acceptance, the
// per-lane 32x32 products in the next cycle (S_MUL), and then the saturating
// accumulator update (S_ACC). An item marked last then waits in S_EMIT to
// clamp the four sums into the output register; that state stretches while
// a previous result still waits in the output register. Configuration writes
// are taken in any cycle (ready is always high) and must only be issued while
// the block is idle.
module dequant_int8_weight_mac_4ch_top
    import dqm_pkg::*;
#(
    parameter int LANES = DQM_LANES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_operation,
    input  logic [CH_W-1:0]          i_channel,
    input  logic signed [DATA_W-1:0] i_scale,
    input  logic signed [DATA_W-1:0] i_offset,
    input  logic signed [DATA_W-1:0] i_prior_sum,
    input  logic signed [DATA_W-1:0] i_bias,
    input  logic signed [DATA_W-1:0] i_activation,
    input  logic signed [WGT_W-1:0]  i_weight0,
    input  logic signed [WGT_W-1:0]  i_weight1,
    input  logic signed [WGT_W-1:0]  i_weight2,
    input  logic signed [WGT_W-1:0]  i_weight3,
    input  logic                     i_last,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_result_ch0,
    output logic signed [DATA_W-1:0] o_result_ch1,
    output logic signed [DATA_W-1:0] o_result_ch2,
    output logic signed [DATA_W-1:0] o_result_ch3
);

    t_dqm_cmd                 cmd;
    t_dqm_sts                 sts;
    logic signed [WGT_W-1:0]  weights [DQM_RESULTS];
    logic signed [DATA_W-1:0] results [DQM_RESULTS];

    assign o_cfg_ready = 1'b1;

    assign weights[0] = i_weight0;
    assign weights[1] = i_weight1;
    assign weights[2] = i_weight2;
    assign weights[3] = i_weight3;

    assign o_result_ch0 = results[0];
    assign o_result_ch1 = results[1];
    assign o_result_ch2 = results[2];
    assign o_result_ch3 = results[3];

    dqm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_last      (i_last),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dqm_datapath #(
        .LANES (LANES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_channel    (i_channel),
        .i_scale      (i_scale),
        .i_offset     (i_offset),
        .i_prior_sum  (i_prior_sum),
        .i_bias       (i_bias),
        .i_activation (i_activation),
        .i_weight     (weights),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (results)
    );

endmodule

>>> src/dqm_ctrl.sv
// ---------------------------------------------------------------------------
// dqm_ctrl
// Sequencer: accepts one item at a time and steps the lane datapath through
// dequantize, multiply, accumulate and emit.
// ---------------------------------------------------------------------------
`include "dequant_int8_weight_mac_4ch_top_assert.svh"

module dqm_ctrl
    import dqm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_operation,
    input  logic     i_last,
    input  t_dqm_sts i_sts,
    output t_dqm_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   in_beat;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_beat    = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.setup_we = in_beat && (i_operation == OP_SETUP);
        o_cmd.deq_load = in_beat && (i_operation == OP_ACCUM);
        o_cmd.mul_en   = (r_state == S_MUL);
        o_cmd.acc_en   = (r_state == S_ACC);
        o_cmd.out_load = (r_state == S_EMIT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_last = i_last;
                    if (i_operation == OP_ACCUM) begin
                        n_state = S_MUL;
                    end else if (i_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    `DQM_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> r_state == S_IDLE, "reset did not return to idle")
    `DQM_ASSERT(a_acc_to_mul, i_clk, i_rst_n, o_cmd.deq_load |=> o_cmd.mul_en, "accumulate beat did not start multiply")
    `DQM_ASSERT(a_mul_to_acc, i_clk, i_rst_n, o_cmd.mul_en |=> o_cmd.acc_en, "multiply not followed by accumulate")
    `DQM_ASSERT(a_emit_done, i_clk, i_rst_n, o_cmd.out_load |=> o_in_ready, "emit did not release input")

endmodule

>>> src/dqm_datapath.sv
// ---------------------------------------------------------------------------
// dqm_datapath
// Per-lane scale/offset/accumulator storage, dequantize and multiply stages,
// saturating accumulate, clamp and output register, configuration registers.
// ---------------------------------------------------------------------------
module dqm_datapath
    import dqm_pkg::*;
#(
    parameter int LANES = DQM_LANES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dqm_cmd                 i_cmd,
    output t_dqm_sts                 o_sts,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic [CH_W-1:0]          i_channel,
    input  logic signed [DATA_W-1:0] i_scale,
    input  logic signed [DATA_W-1:0] i_offset,
    input  logic signed [DATA_W-1:0] i_prior_sum,
    input  logic signed [DATA_W-1:0] i_bias,
    input  logic signed [DATA_W-1:0] i_activation,
    input  logic signed [WGT_W-1:0]  i_weight [DQM_RESULTS],
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_result [DQM_RESULTS]
);

    // only lanes that have weight and result ports carry hardware
    localparam int NACT = (LANES < DQM_RESULTS) ? LANES : DQM_RESULTS;

    logic signed [DATA_W-1:0] r_clamp_low, r_clamp_high;
    logic                     r_acc_prior, r_bias_en;
    logic signed [DATA_W-1:0] r_act;
    logic signed [DATA_W-1:0] r_scale [NACT];
    logic signed [DATA_W-1:0] r_offset [NACT];
    logic signed [DATA_W-1:0] r_acc [NACT];
    logic signed [DATA_W-1:0] r_wq [NACT];
    logic signed [63:0]       r_prod [NACT];
    logic signed [DATA_W-1:0] r_res [DQM_RESULTS];
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] n_start;
    logic signed [DATA_W-1:0] prior_term, bias_term;

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;

    assign prior_term = r_acc_prior ? i_prior_sum : '0;
    assign bias_term  = r_bias_en ? i_bias : '0;
    assign n_start    = sat32(64'(prior_term) + 64'(bias_term));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_low  <= 32'sh8000_0000;
            r_clamp_high <= 32'sh7FFF_FFFF;
            r_acc_prior  <= 1'b0;
            r_bias_en    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CLAMP_LOW:  r_clamp_low  <= signed'(i_cfg_data);
                CFG_CLAMP_HIGH: r_clamp_high <= signed'(i_cfg_data);
                CFG_ACC_PRIOR:  r_acc_prior  <= i_cfg_data[0];
                CFG_BIAS_EN:    r_bias_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.deq_load) begin
            r_act <= i_activation;
        end
    end

    for (genvar g = 0; g < NACT; g++) begin : g_lane
        logic signed [WGT_W+DATA_W-1:0] deq_mul;
        logic signed [WGT_W+DATA_W:0]   deq_sum;
        logic signed [63:0]             acc_sum;
        logic signed [DATA_W-1:0]       n_acc;

        assign deq_mul = i_weight[g] * r_scale[g];
        assign deq_sum = (WGT_W+DATA_W+1)'(deq_mul) + (WGT_W+DATA_W+1)'(r_offset[g]);
        // floor to Q16.16 is an arithmetic shift of the Q32.32 product
        assign acc_sum = 64'(r_acc[g]) + (r_prod[g] >>> FRAC_W);
        assign n_acc   = sat32(acc_sum);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_scale[g]  <= '0;
                r_offset[g] <= '0;
                r_acc[g]    <= '0;
            end else if (i_cmd.setup_we && (i_channel == CH_W'(g))) begin
                r_scale[g]  <= i_scale;
                r_offset[g] <= i_offset;
                r_acc[g]    <= n_start;
            end else if (i_cmd.acc_en) begin
                r_acc[g]    <= n_acc;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.deq_load) begin
                r_wq[g] <= sat32(64'(deq_sum));
            end
            if (i_cmd.mul_en) begin
                r_prod[g] <= r_wq[g] * r_act;
            end
        end
    end

    for (genvar g = 0; g < DQM_RESULTS; g++) begin : g_out
        logic signed [DATA_W-1:0] sum_val;

        if (g < NACT) begin : g_act
            assign sum_val = r_acc[g];
        end else begin : g_zero
            assign sum_val = '0;
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.out_load) begin
                r_res[g] <= clamp32(sum_val, r_clamp_low, r_clamp_high);
            end
        end

        assign o_result[g] = r_res[g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
